FILE: sv/ovle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_pkg
// Shared constants for the ordered value list engine: sizes, op codes and
// result status codes.
// ----------------------------------------------------------------------------
package ovle_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [DATA_W-1:0]   data_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_DUMP   = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    localparam status_t STS_INSERTED      = 3'd0;
    localparam status_t STS_FULL          = 3'd1;
    localparam status_t STS_DELETED       = 3'd2;
    localparam status_t STS_DELETED_EMPTY = 3'd3;
    localparam status_t STS_NOT_FOUND     = 3'd4;
    localparam status_t STS_DELETE_EMPTY  = 3'd5;
    localparam status_t STS_ELEMENT       = 3'd6;
    localparam status_t STS_EMPTY         = 3'd7;

endpackage

FILE: sv/ovle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ovle_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ordered_value_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list_engine
// Front-first list of signed 32-bit values in a small RAM, driven by one
// operation per input transfer, under a sequencer with one shared compare.
//
//   channel  direction  ports
//   s_       in         s_valid s_ready s_op s_value
//   m_       out        m_valid m_ready m_status m_value_out m_count m_last
//
// Insert moves every entry up one slot and writes the value at the front, or
// is rejected as full; delete probes from the front for the first match and
// moves each later entry down one slot; dump reads out every entry in order
// from the front; clear empties the list.
// Reset empties the list; RAM contents are left as they are.
// s_ready is high only while the sequencer is idle; a held m_ transfer
// stalls the sequencer only at the point where it has a result to hand over.
// ----------------------------------------------------------------------------
module ordered_value_list_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ovle_pkg::OP_W-1:0]           s_op,
    input  logic signed [ovle_pkg::DATA_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ovle_pkg::STATUS_W-1:0]       m_status,
    output logic signed [ovle_pkg::DATA_W-1:0]  m_value_out,
    output logic [ovle_pkg::COUNT_W-1:0]        m_count,
    output logic                                m_last
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EMIT     = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_INS_HEAD = 4'd4;
    localparam logic [3:0] S_DEL_RD   = 4'd5;
    localparam logic [3:0] S_DEL_CMP  = 4'd6;
    localparam logic [3:0] S_SH_RD    = 4'd7;
    localparam logic [3:0] S_SH_WR    = 4'd8;
    localparam logic [3:0] S_DUMP_RD  = 4'd9;
    localparam logic [3:0] S_DUMP_OUT = 4'd10;

    logic [3:0]          state_reg,  state_next;
    ovle_pkg::cnt_t      count_reg,  count_next;
    ovle_pkg::cnt_t      idx_reg,    idx_next;
    ovle_pkg::data_t     val_reg,    val_next;
    ovle_pkg::status_t   res_reg,    res_next;

    logic                m_valid_reg, m_valid_next;
    ovle_pkg::status_t   m_status_reg, m_status_next;
    ovle_pkg::data_t     m_value_reg,  m_value_next;
    ovle_pkg::cnt_t      m_cnt_reg,    m_cnt_next;
    logic                m_last_reg,   m_last_next;

    logic                we;
    ovle_pkg::addr_t     waddr;
    ovle_pkg::data_t     wdata;
    ovle_pkg::addr_t     raddr;
    ovle_pkg::data_t     rdata;
    logic                out_free;
    logic                accept;
    ovle_pkg::cnt_t      count_dec;

    ovle_ram #(
        .DEPTH  (ovle_pkg::CAPACITY),
        .ADDR_W (ovle_pkg::ADDR_W),
        .DATA_W (ovle_pkg::DATA_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign count_dec = ovle_pkg::CNT_W'(count_reg - 1'b1);

    always_comb begin
        case (state_reg)
            S_INS_RD: raddr = ovle_pkg::ADDR_W'(idx_reg - 1'b1);
            S_SH_RD:  raddr = ovle_pkg::ADDR_W'(idx_reg + 1'b1);
            default:  raddr = idx_reg[ovle_pkg::ADDR_W-1:0];
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_cnt_next    = m_cnt_reg;
        m_last_next   = m_last_reg;
        we            = 1'b0;
        waddr         = idx_reg[ovle_pkg::ADDR_W-1:0];
        wdata         = rdata;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    val_next = s_value;
                    idx_next = '0;
                    case (s_op)
                        ovle_pkg::OP_INSERT: begin
                            if (count_reg >= ovle_pkg::CAPACITY) begin
                                res_next   = ovle_pkg::STS_FULL;
                                state_next = S_EMIT;
                            end else if (count_reg == '0) begin
                                state_next = S_INS_HEAD;
                            end else begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        ovle_pkg::OP_DELETE: begin
                            if (count_reg == '0) begin
                                res_next   = ovle_pkg::STS_DELETE_EMPTY;
                                state_next = S_EMIT;
                            end else begin
                                state_next = S_DEL_RD;
                            end
                        end
                        ovle_pkg::OP_DUMP: begin
                            if (count_reg == '0) begin
                                res_next   = ovle_pkg::STS_EMPTY;
                                state_next = S_EMIT;
                            end else begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default: begin
                            count_next = '0;
                            res_next   = ovle_pkg::STS_EMPTY;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_value_next  = val_reg;
                    m_cnt_next    = count_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_INS_RD: begin
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                we       = 1'b1;
                idx_next = ovle_pkg::CNT_W'(idx_reg - 1'b1);
                if (idx_reg == ovle_pkg::CNT_W'(1)) begin
                    state_next = S_INS_HEAD;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_HEAD: begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = val_reg;
                count_next = ovle_pkg::CNT_W'(count_reg + 1'b1);
                res_next   = ovle_pkg::STS_INSERTED;
                state_next = S_EMIT;
            end
            S_DEL_RD: begin
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (rdata == val_reg) begin
                    if (idx_reg + 1 < count_reg) begin
                        state_next = S_SH_RD;
                    end else begin
                        count_next = count_dec;
                        res_next   = (count_dec == '0) ? ovle_pkg::STS_DELETED_EMPTY
                                                       : ovle_pkg::STS_DELETED;
                        state_next = S_EMIT;
                    end
                end else if (idx_reg + 1 >= count_reg) begin
                    res_next   = ovle_pkg::STS_NOT_FOUND;
                    state_next = S_EMIT;
                end else begin
                    idx_next   = ovle_pkg::CNT_W'(idx_reg + 1'b1);
                    state_next = S_DEL_RD;
                end
            end
            S_SH_RD: begin
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                we       = 1'b1;
                idx_next = ovle_pkg::CNT_W'(idx_reg + 1'b1);
                if (idx_reg + 2 < count_reg) begin
                    state_next = S_SH_RD;
                end else begin
                    count_next = count_dec;
                    res_next   = (count_dec == '0) ? ovle_pkg::STS_DELETED_EMPTY
                                                   : ovle_pkg::STS_DELETED;
                    state_next = S_EMIT;
                end
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ovle_pkg::STS_ELEMENT;
                    m_value_next  = rdata;
                    m_cnt_next    = count_reg;
                    m_last_next   = (idx_reg + 1 == count_reg);
                    if (idx_reg + 1 == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = ovle_pkg::CNT_W'(idx_reg + 1'b1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_cnt_reg    <= m_cnt_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_out = m_value_reg;
    assign m_count     = ovle_pkg::COUNT_W'(m_cnt_reg);
    assign m_last      = m_last_reg;

endmodule
